[rtl/tcq_pkg.sv]
package tcq_pkg;

	// register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_RATIO_BOUND  = 2'd0;
	localparam cfg_idx_t REG_RADIUS_BOUND = 2'd1;

	// field widths fixed by the result format
	localparam int RATIO_W    = 24;
	localparam int RATIO_FRAC = 16;
	localparam int RADIUS_W   = 48;
	localparam int CENTER_W   = 32;
	localparam int SHORT_W    = 33;

	localparam logic [RATIO_W-1:0]  RATIO_RESET = 24'd65536;
	localparam logic [RADIUS_W-1:0] RADIUS_MAX  = '1;

	// quotient bits kept by the radius and center dividers
	localparam int RAD_QB = RADIUS_W + 1;
	localparam int CEN_QB = 41;

endpackage

[rtl/tcq_delay.sv]
module tcq_delay #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_s [N];

	// plain shift line, no reset on payload
	always_ff @(posedge clk) begin
		line_s[0] <= d;
		for (int k = 1; k < N; k++) begin
			line_s[k] <= line_s[k-1];
		end
	end

	assign q = line_s[N-1];

endmodule

[rtl/tcq_mul.sv]
module tcq_mul #(
	parameter int A_W = 32,
	parameter int B_W = 32
) (
	input  logic               clk,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic [A_W+B_W-1:0] prod
);

	localparam int CHUNK  = 32;
	localparam int NCH    = (A_W + CHUNK - 1) / CHUNK;
	localparam int EXT_W  = NCH * CHUNK;
	localparam int PART_W = CHUNK + B_W;
	localparam int P_W    = A_W + B_W;

	logic [EXT_W-1:0]  a_ext;
	logic [PART_W-1:0] part_s1 [NCH];
	logic [P_W-1:0]    sum;

	assign a_ext = EXT_W'(a);

	// one 32-bit slice of a times b per partial product
	always_ff @(posedge clk) begin
		for (int k = 0; k < NCH; k++) begin
			part_s1[k] <= PART_W'(a_ext[k*CHUNK +: CHUNK]) * PART_W'(b);
		end
	end

	// shifted partial products summed
	always_comb begin
		sum = '0;
		for (int k = 0; k < NCH; k++) begin
			sum = sum + (P_W'(part_s1[k]) << (k * CHUNK));
		end
	end

	always_ff @(posedge clk) begin
		prod <= sum;
	end

endmodule

[rtl/tcq_div.sv]
module tcq_div #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 8,
	parameter int QB    = 8
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QB:0]      quo,
	output logic             ovf
);

	localparam int W = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1;

	logic [W-1:0]     rem_s [QB+1];
	logic [DEN_W-1:0] den_s [QB+1];
	logic [QB-1:0]    quo_s [QB+1];
	logic             ovf_s [QB+1];
	logic             round_up;

	// load, and flag a quotient that needs more than QB bits
	always_ff @(posedge clk) begin
		rem_s[0] <= W'(num);
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= W'(num) >= (W'(den) << QB);
	end

	// one restoring step per stage, msb first
	for (genvar i = 1; i <= QB; i++) begin : g_step
		localparam int J = QB - i;
		logic [W-1:0] trial;
		logic         fits;

		assign trial = W'(den_s[i-1]) << J;
		assign fits  = rem_s[i-1] >= trial;

		always_ff @(posedge clk) begin
			rem_s[i] <= fits ? rem_s[i-1] - trial : rem_s[i-1];
			quo_s[i] <= quo_s[i-1] | (fits ? (QB'(1) << J) : QB'(0));
			den_s[i] <= den_s[i-1];
			ovf_s[i] <= ovf_s[i-1];
		end
	end

	// round to nearest, ties up
	assign round_up = {rem_s[QB], 1'b0} >= (W+1)'(den_s[QB]);

	always_ff @(posedge clk) begin
		quo <= (QB+1)'(quo_s[QB]) + (QB+1)'(round_up);
		ovf <= ovf_s[QB];
	end

endmodule

[rtl/triangle_circumcircle_quality_unit.sv]
// channel  | handshake                  | payload
// request  | start, busy                | ax, ay, bx, by_coord, cx, cy
// result   | done (one-cycle strobe)    | center_x, center_y, radius_sq, shortest_sq,
//          |                            | bad, degenerate
// config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// one request per clock; each result follows its request through
// a 6-stage front end, the 51-stage radius divider
// (49 quotient steps plus load and rounding) and the output register
// busy and cfg_ready are constant, the pipeline never stops
// arst_n clears the valid line and loads the bound registers with their reset values; payload is not reset
module triangle_circumcircle_quality_unit import tcq_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by_coord,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	output logic                         done,
	output logic signed [CENTER_W-1:0]   center_x,
	output logic signed [CENTER_W-1:0]   center_y,
	output logic [RADIUS_W-1:0]          radius_sq,
	output logic [SHORT_W-1:0]           shortest_sq,
	output logic                         bad,
	output logic                         degenerate,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  cfg_idx_t                     cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int CB   = COORD_BITS;
	localparam int FB   = FRAC_BITS;
	localparam int DW   = CB + 1;
	localparam int SW   = 2 * CB + 1;
	localparam int XW   = 2 * DW;
	localparam int TW   = DW + SW + 1;
	localparam int NW   = TW + 1;
	localparam int CMW  = 2 * CB + 1;
	localparam int PW   = 3 * SW;
	localparam int D4W  = 2 * CMW + 2;
	localparam int M4W  = D4W + SW;
	localparam int RHW  = M4W + RATIO_W;
	localparam int LW   = PW + RATIO_FRAC;
	localparam int CMPW = (LW > RHW) ? LW : RHW;
	localparam int VW   = CB + FB + CEN_QB + 3;

	localparam int CEN_OUT = 5 + CEN_QB + 2;
	localparam int RAD_OUT = 6 + RAD_QB + 2;
	localparam int DONE_ST = RAD_OUT + 1;

	localparam logic [CEN_QB:0] CEN_LIM     = (CEN_QB+1)'(1) << (CEN_QB - 1);
	localparam logic [RAD_QB:0] RAD_MAX_EXT = (RAD_QB+1)'(RADIUS_MAX);

	logic accept;
	logic [DONE_ST-1:0] vld_s;
	logic [RATIO_W-1:0]  ratio_q;
	logic [RADIUS_W-1:0] radius_q;

	// stage 1
	logic signed [DW-1:0] da_s1, db_s1, dc_s1, dd_s1, dh_s1, di_s1;
	logic signed [CB-1:0] ax_s1, ay_s1;
	// stage 2
	logic signed [2*DW-1:0] sq_a, sq_b, sq_c, sq_d, sq_h, sq_i, pr_ad, pr_bc;
	logic [SW-1:0] ab_s2, bc_s2, ca_s2;
	logic signed [2*DW-1:0] pad_s2, pbc_s2;
	logic signed [DW-1:0] da_s2, db_s2, dc_s2, dd_s2;
	logic signed [CB-1:0] ax_s2, ay_s2;
	// stage 3
	logic [SW-1:0] sh_ab_bc;
	logic signed [SW:0] ab_sx, ca_sx;
	logic signed [XW-1:0] cross_s3;
	logic [SW-1:0] shortest_s3, ca_s3;
	logic signed [TW-1:0] t_dab_s3, t_bca_s3, t_aca_s3, t_cab_s3;
	logic signed [CB-1:0] ax_s3, ay_s3;
	// stage 4
	logic [2*SW-1:0] abbc_s4;
	logic signed [NW-1:0] nx_s4, ny_s4;
	logic [CMW-1:0] cm_s4;
	logic deg_s4, ncr_s4;
	logic [SW-1:0] shortest_s4, ca_s4;
	logic signed [CB-1:0] ax_s4, ay_s4;
	// stage 5
	logic [NW-1:0] mnx_s5, mny_s5;
	logic negx_s5, negy_s5;
	logic [CMW:0] den2_s5;
	// stage 6 and later
	logic [PW-1:0] prod_s6;
	logic [2*CMW-1:0] cmsq_s6;
	logic [D4W-1:0] den4;
	logic [SW-1:0] shortest_s6;
	logic [M4W-1:0] m4_s8;
	logic [RHW-1:0] rhs_s10;
	logic [LW-1:0] lhs_s10;
	logic ratio_bad_s11;
	logic [CEN_QB:0] cqx_s48, cqy_s48;
	logic covfx_s48, covfy_s48;
	logic [CEN_QB:0] cqx_s57, cqy_s57;
	logic covfx_s57, covfy_s57;
	logic [RAD_QB:0] rq_s57;
	logic rovf_s57;
	logic negx_s57, negy_s57, ratio_bad_s57, deg_s57;
	logic signed [CB-1:0] ax_s57, ay_s57;
	logic [SW-1:0] shortest_s57;
	logic [RADIUS_W-1:0] rsq_fin;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// bound registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= RATIO_RESET;
			radius_q <= RADIUS_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RATIO_BOUND:  ratio_q  <= cfg_data[RATIO_W-1:0];
				REG_RADIUS_BOUND: radius_q <= cfg_data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[DONE_ST-2:0], accept};
		end
	end

	// stage 1: edge vectors
	always_ff @(posedge clk) begin
		da_s1 <= DW'(bx) - DW'(ax);
		db_s1 <= DW'(by_coord) - DW'(ay);
		dc_s1 <= DW'(cx) - DW'(ax);
		dd_s1 <= DW'(cy) - DW'(ay);
		dh_s1 <= DW'(cx) - DW'(bx);
		di_s1 <= DW'(cy) - DW'(by_coord);
		ax_s1 <= ax;
		ay_s1 <= ay;
	end

	// stage 2: squared edges and cross terms
	assign sq_a  = da_s1 * da_s1;
	assign sq_b  = db_s1 * db_s1;
	assign sq_c  = dc_s1 * dc_s1;
	assign sq_d  = dd_s1 * dd_s1;
	assign sq_h  = dh_s1 * dh_s1;
	assign sq_i  = di_s1 * di_s1;
	assign pr_ad = da_s1 * dd_s1;
	assign pr_bc = db_s1 * dc_s1;

	always_ff @(posedge clk) begin
		ab_s2  <= SW'(sq_a + sq_b);
		bc_s2  <= SW'(sq_h + sq_i);
		ca_s2  <= SW'(sq_c + sq_d);
		pad_s2 <= pr_ad;
		pbc_s2 <= pr_bc;
		da_s2  <= da_s1;
		db_s2  <= db_s1;
		dc_s2  <= dc_s1;
		dd_s2  <= dd_s1;
		ax_s2  <= ax_s1;
		ay_s2  <= ay_s1;
	end

	// stage 3: cross product, shortest edge, center numerator terms
	assign sh_ab_bc = (ab_s2 < bc_s2) ? ab_s2 : bc_s2;
	assign ab_sx    = $signed({1'b0, ab_s2});
	assign ca_sx    = $signed({1'b0, ca_s2});

	always_ff @(posedge clk) begin
		cross_s3    <= pad_s2 - pbc_s2;
		shortest_s3 <= (sh_ab_bc > ca_s2) ? ca_s2 : sh_ab_bc;
		t_dab_s3    <= dd_s2 * ab_sx;
		t_bca_s3    <= db_s2 * ca_sx;
		t_aca_s3    <= da_s2 * ca_sx;
		t_cab_s3    <= dc_s2 * ab_sx;
		ca_s3       <= ca_s2;
		ax_s3       <= ax_s2;
		ay_s3       <= ay_s2;
	end

	tcq_mul #(.A_W(SW), .B_W(SW)) u_mul_abbc (
		.clk (clk),
		.a   (ab_s2),
		.b   (bc_s2),
		.prod(abbc_s4)
	);

	// stage 4: numerators, cross magnitude and sign
	always_ff @(posedge clk) begin
		nx_s4       <= NW'(t_dab_s3) - NW'(t_bca_s3);
		ny_s4       <= NW'(t_aca_s3) - NW'(t_cab_s3);
		cm_s4       <= CMW'(cross_s3[XW-1] ? -cross_s3 : cross_s3);
		deg_s4      <= cross_s3 == '0;
		ncr_s4      <= cross_s3[XW-1];
		shortest_s4 <= shortest_s3;
		ca_s4       <= ca_s3;
		ax_s4       <= ax_s3;
		ay_s4       <= ay_s3;
	end

	// stage 5: unsigned operands for the center dividers
	always_ff @(posedge clk) begin
		mnx_s5  <= nx_s4[NW-1] ? NW'(-nx_s4) : NW'(nx_s4);
		mny_s5  <= ny_s4[NW-1] ? NW'(-ny_s4) : NW'(ny_s4);
		negx_s5 <= nx_s4[NW-1] ^ ncr_s4;
		negy_s5 <= ny_s4[NW-1] ^ ncr_s4;
		den2_s5 <= {cm_s4, 1'b0};
	end

	tcq_mul #(.A_W(2*SW), .B_W(SW)) u_mul_prod (
		.clk (clk),
		.a   (abbc_s4),
		.b   (ca_s4),
		.prod(prod_s6)
	);

	tcq_mul #(.A_W(CMW), .B_W(CMW)) u_mul_cmsq (
		.clk (clk),
		.a   (cm_s4),
		.b   (cm_s4),
		.prod(cmsq_s6)
	);

	tcq_div #(.NUM_W(NW+FB), .DEN_W(CMW+1), .QB(CEN_QB)) u_div_cx (
		.clk(clk),
		.num((NW+FB)'(mnx_s5) << FB),
		.den(den2_s5),
		.quo(cqx_s48),
		.ovf(covfx_s48)
	);

	tcq_div #(.NUM_W(NW+FB), .DEN_W(CMW+1), .QB(CEN_QB)) u_div_cy (
		.clk(clk),
		.num((NW+FB)'(mny_s5) << FB),
		.den(den2_s5),
		.quo(cqy_s48),
		.ovf(covfy_s48)
	);

	// stage 6: radius quotient and ratio test operands
	assign den4 = D4W'(cmsq_s6) << 2;

	tcq_div #(.NUM_W(PW+FB), .DEN_W(D4W), .QB(RAD_QB)) u_div_rad (
		.clk(clk),
		.num((PW+FB)'(prod_s6) << FB),
		.den(den4),
		.quo(rq_s57),
		.ovf(rovf_s57)
	);

	tcq_delay #(.W(SW), .N(2)) u_dly_short (
		.clk(clk),
		.d  (shortest_s4),
		.q  (shortest_s6)
	);

	tcq_mul #(.A_W(D4W), .B_W(SW)) u_mul_rhs1 (
		.clk (clk),
		.a   (den4),
		.b   (shortest_s6),
		.prod(m4_s8)
	);

	tcq_mul #(.A_W(M4W), .B_W(RATIO_W)) u_mul_rhs2 (
		.clk (clk),
		.a   (m4_s8),
		.b   (ratio_q),
		.prod(rhs_s10)
	);

	tcq_delay #(.W(LW), .N(4)) u_dly_lhs (
		.clk(clk),
		.d  (LW'(prod_s6) << RATIO_FRAC),
		.q  (lhs_s10)
	);

	// exact ratio compare
	always_ff @(posedge clk) begin
		ratio_bad_s11 <= CMPW'(lhs_s10) > CMPW'(rhs_s10);
	end

	// align side data with the radius quotient
	tcq_delay #(.W(2*CB+1+SW), .N(RAD_OUT-4)) u_dly_side (
		.clk(clk),
		.d  ({ax_s4, ay_s4, deg_s4, shortest_s4}),
		.q  ({ax_s57, ay_s57, deg_s57, shortest_s57})
	);

	tcq_delay #(.W(2), .N(RAD_OUT-5)) u_dly_neg (
		.clk(clk),
		.d  ({negx_s5, negy_s5}),
		.q  ({negx_s57, negy_s57})
	);

	tcq_delay #(.W(2*CEN_QB+4), .N(RAD_OUT-CEN_OUT)) u_dly_cen (
		.clk(clk),
		.d  ({cqx_s48, covfx_s48, cqy_s48, covfy_s48}),
		.q  ({cqx_s57, covfx_s57, cqy_s57, covfy_s57})
	);

	tcq_delay #(.W(1), .N(RAD_OUT-11)) u_dly_ratio (
		.clk(clk),
		.d  (ratio_bad_s11),
		.q  (ratio_bad_s57)
	);

	// base plus signed offset, saturated to the center format; zero for a degenerate triangle
	function automatic logic [CENTER_W-1:0] center_fix(
		input logic signed [CB-1:0] base,
		input logic [CEN_QB:0]      q,
		input logic                 ovf,
		input logic                 neg,
		input logic                 dgn
	);
		logic signed [VW-1:0] v;
		logic signed [VW-1:0] off;
		logic [VW-CENTER_W:0] hi;
		logic [CENTER_W-1:0]  res;
		off = $signed(VW'(q));
		v   = (VW'(base) <<< FB);
		v   = neg ? v - off : v + off;
		hi  = v[VW-1:CENTER_W-1];
		if (dgn) begin
			res = '0;
		end else if (ovf || q > CEN_LIM) begin
			res = neg ? {1'b1, {(CENTER_W-1){1'b0}}} : {1'b0, {(CENTER_W-1){1'b1}}};
		end else if (hi == '0 || hi == '1) begin
			res = v[CENTER_W-1:0];
		end else begin
			res = v[VW-1] ? {1'b1, {(CENTER_W-1){1'b0}}} : {1'b0, {(CENTER_W-1){1'b1}}};
		end
		return res;
	endfunction

	// radius with saturation, degenerate forces maximum
	assign rsq_fin = (deg_s57 || rovf_s57 || rq_s57 > RAD_MAX_EXT) ? RADIUS_MAX
		: rq_s57[RADIUS_W-1:0];

	// output register
	always_ff @(posedge clk) begin
		center_x    <= center_fix(ax_s57, cqx_s57, covfx_s57, negx_s57, deg_s57);
		center_y    <= center_fix(ay_s57, cqy_s57, covfy_s57, negy_s57, deg_s57);
		radius_sq   <= rsq_fin;
		shortest_sq <= SHORT_W'(shortest_s57);
		bad         <= deg_s57 || ratio_bad_s57 || (rsq_fin > radius_q);
		degenerate  <= deg_s57;
	end

	assign done = vld_s[DONE_ST-1];

	// checks
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, DONE_ST))
		else $error("result without a request at the pipeline depth");

	a_degen_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> bad)
		else $error("degenerate triangle not marked bad");

	a_degen_values: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (radius_sq == RADIUS_MAX && center_x == '0 && center_y == '0))
		else $error("degenerate triangle with nonzero center or finite radius");

endmodule

[tb/sv/triangle_circumcircle_quality_unit_test.sv]
`timescale 1ns / 100ps

module triangle_circumcircle_quality_unit_test import tcq_pkg::*; ();

	localparam int CRD_W = 16;
	localparam int FRAC = 8;
	localparam int LIMIT_CYCLES = 400000;
	localparam cfg_idx_t REG_SPARE = 2'd3;

	typedef struct {
		logic signed [CRD_W-1:0] ax, ay, bx, by, cx, cy;
	} triangle_t;

	typedef struct {
		logic signed [CENTER_W-1:0] center_x, center_y;
		logic [RADIUS_W-1:0]        radius_sq;
		logic [SHORT_W-1:0]         shortest_sq;
		logic                       bad, degenerate;
	} quality_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [CRD_W-1:0] ax = '0, ay = '0, bx = '0, by_coord = '0, cx = '0, cy = '0;
	logic cfg_valid = 1'b0;
	cfg_idx_t cfg_index = REG_RATIO_BOUND;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	wire busy, done, bad, degenerate, cfg_ready;
	wire signed [CENTER_W-1:0] center_x, center_y;
	wire [RADIUS_W-1:0] radius_sq;
	wire [SHORT_W-1:0] shortest_sq;

	triangle_circumcircle_quality_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord), .cx(cx), .cy(cy),
		.done(done), .center_x(center_x), .center_y(center_y), .radius_sq(radius_sq),
		.shortest_sq(shortest_sq), .bad(bad), .degenerate(degenerate),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copies of the bound registers
	logic [RATIO_W-1:0]  ratio_bound = RATIO_RESET;
	logic [RADIUS_W-1:0] radius_bound = RADIUS_MAX;

	triangle_t pending_tris[$];
	quality_t  expected_q[$];
	triangle_t drv_tri;
	int        gap_pct = 0;
	int        fail_count = 0;
	int        cycle_count = 0;

	// one circumcenter coordinate: base + num / (2 cross), rounded, saturated
	function automatic logic [CENTER_W-1:0] center_fix(longint base, longint num, longint cr);
		logic [127:0] mag_n, mag_c, q;
		longint v;
		bit neg;
		neg = (num < 0) != (cr < 0);
		mag_n = (num < 0) ? -num : num;
		mag_c = (cr < 0) ? -cr : cr;
		q = ((mag_n << (FRAC + 1)) + (mag_c << 1)) / (mag_c << 2);
		if (q > (128'd1 << 40)) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		v = base * (longint'(1) << FRAC);
		v = neg ? v - longint'(q) : v + longint'(q);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[CENTER_W-1:0];
	endfunction

	// quality of one triangle under the current bounds
	function automatic quality_t grade_triangle(triangle_t t);
		longint a, b, c, d, h, i, ab, bc, ca, sh, cr;
		logic [191:0] prod, den4, r, lhs, rhs;
		quality_t res;
		a = longint'(t.bx) - longint'(t.ax);
		b = longint'(t.by) - longint'(t.ay);
		c = longint'(t.cx) - longint'(t.ax);
		d = longint'(t.cy) - longint'(t.ay);
		h = longint'(t.cx) - longint'(t.bx);
		i = longint'(t.cy) - longint'(t.by);
		ab = a * a + b * b;
		bc = h * h + i * i;
		ca = c * c + d * d;
		sh = (ab < bc) ? ab : bc;
		if (sh > ca) sh = ca;
		cr = a * d - b * c;
		res.shortest_sq = sh[SHORT_W-1:0];
		if (cr == 0) begin
			res.center_x = '0;
			res.center_y = '0;
			res.radius_sq = RADIUS_MAX;
			res.bad = 1'b1;
			res.degenerate = 1'b1;
			return res;
		end
		prod = 192'(ab) * 192'(bc) * 192'(ca);
		den4 = 192'((cr < 0) ? -cr : cr);
		den4 = (den4 * den4) << 2;
		r = ((prod << (FRAC + 1)) + den4) / (den4 << 1);
		res.radius_sq = (r > 192'(RADIUS_MAX)) ? RADIUS_MAX : r[RADIUS_W-1:0];
		lhs = prod << RATIO_FRAC;
		rhs = den4 * 192'(sh) * 192'(ratio_bound);
		res.bad = (lhs > rhs) || (res.radius_sq > radius_bound);
		res.degenerate = 1'b0;
		res.center_x = center_fix(longint'(t.ax), d * ab - b * ca, cr);
		res.center_y = center_fix(longint'(t.ay), a * ca - c * ab, cr);
		return res;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_q.push_back(grade_triangle(drv_tri));
				void'(pending_tris.pop_front());
			end
			if (pending_tris.size() > 0 && $urandom_range(99) >= gap_pct) begin
				drv_tri = pending_tris[0];
				start <= 1'b1;
				ax <= drv_tri.ax;
				ay <= drv_tri.ay;
				bx <= drv_tri.bx;
				by_coord <= drv_tri.by;
				cx <= drv_tri.cx;
				cy <= drv_tri.cy;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		quality_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got center %0h,%0h",
					$time, center_x, center_y);
				fail_count++;
			end else begin
				e = expected_q.pop_front();
				check_field("center_x", 64'(e.center_x), 64'(center_x));
				check_field("center_y", 64'(e.center_y), 64'(center_y));
				check_field("radius_sq", 64'(e.radius_sq), 64'(radius_sq));
				check_field("shortest_sq", 64'(e.shortest_sq), 64'(shortest_sq));
				check_field("bad", 64'(e.bad), 64'(bad));
				check_field("degenerate", 64'(e.degenerate), 64'(degenerate));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_bound(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_RATIO_BOUND) ratio_bound = val[RATIO_W-1:0];
		else if (idx == REG_RADIUS_BOUND) radius_bound = val[RADIUS_W-1:0];
	endtask

	task automatic wait_drained();
		while (pending_tris.size() > 0 || start || expected_q.size() > 0) @(posedge clk);
	endtask

	// coordinates outside the field range wrap to its width
	task automatic add_tri(int a0, int a1, int b0, int b1, int c0, int c1);
		triangle_t t;
		t.ax = CRD_W'(a0); t.ay = CRD_W'(a1);
		t.bx = CRD_W'(b0); t.by = CRD_W'(b1);
		t.cx = CRD_W'(c0); t.cy = CRD_W'(c1);
		pending_tris.push_back(t);
	endtask

	function automatic int rnd_coord();
		return int'($urandom_range(65535)) - 32768;
	endfunction

	// mostly compact triangles, some full range, collinear and thin ones
	task automatic add_random_tri();
		int kind, ox, oy, sp, dx, dy, k;
		kind = $urandom_range(9);
		ox = rnd_coord();
		oy = rnd_coord();
		sp = 1 << $urandom_range(12);
		if (kind < 3) begin
			add_tri(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
				rnd_coord());
		end else if (kind < 8) begin
			add_tri(ox, oy, ox + $urandom_range(2 * sp) - sp, oy + $urandom_range(2 * sp) - sp,
				ox + $urandom_range(2 * sp) - sp, oy + $urandom_range(2 * sp) - sp);
		end else if (kind == 8) begin
			dx = $urandom_range(2 * sp) - sp;
			dy = $urandom_range(2 * sp) - sp;
			k = $urandom_range(3);
			add_tri(ox, oy, ox + dx, oy + dy, ox - k * dx, oy - k * dy);
		end else begin
			dx = $urandom_range(2 * sp) - sp;
			dy = $urandom_range(2 * sp) - sp;
			add_tri(ox, oy, ox + dx, oy + dy, ox + 2 * dx + 1, oy + 2 * dy);
		end
	endtask

	task automatic run_random(int n, int gap);
		gap_pct = gap;
		repeat (n) add_random_tri();
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed triangles at reset bounds
		gap_pct = 0;
		add_tri(0, 0, 1, 0, 0, 1);
		add_tri(0, 0, 4, 0, 2, 3);
		add_tri(-32768, -32768, -32768, -32768, -32768, -32768);
		add_tri(32767, 32767, 32767, 32767, 32767, 32767);
		add_tri(-32768, -32768, 32767, -32768, -32768, 32767);
		add_tri(32767, 32767, -32768, 32767, 32767, -32768);
		add_tri(-32768, 0, 32767, 0, -32768, 1);
		add_tri(-32768, -32768, 32767, 32767, 32767, 32766);
		add_tri(0, 0, 10, 10, 20, 20);
		add_tri(5, 5, 5, 5, 9, -3);
		add_tri(0, 0, 1, 0, 1, 0);
		add_tri(-1, -1, 1, 1, -1, 1);
		add_tri(100, 200, 300, 200, 200, 373);
		add_tri(-32768, 32767, 32767, -32768, 0, 0);
		add_tri(-32768, 32767, 32767, -32768, 0, 1);
		add_tri(0, 0, 3, 0, 0, 4);
		wait_drained();

		// extremes of both bounds, unused index ignored
		write_bound(REG_RATIO_BOUND, 48'd0);
		write_bound(REG_RADIUS_BOUND, 48'd0);
		write_bound(REG_SPARE, '1);
		add_tri(0, 0, 3, 0, 0, 4);
		add_tri(0, 0, 1, 0, 0, 1);
		add_tri(-5, 7, 12, 3, 1, -9);
		wait_drained();
		write_bound(REG_RATIO_BOUND, 48'hFF_FFFF);
		write_bound(REG_RADIUS_BOUND, 48'd800);
		add_tri(0, 0, 3, 0, 0, 4);
		add_tri(-32768, 0, 32767, 0, -32768, 1);
		add_tri(0, 0, 10, 0, 5, 9);
		wait_drained();

		// random phases over several bound settings
		write_bound(REG_RATIO_BOUND, RATIO_RESET);
		write_bound(REG_RADIUS_BOUND, RADIUS_MAX);
		run_random(200, 7);
		write_bound(REG_RATIO_BOUND, 48'(32'd21845 + $urandom_range(200000)));
		write_bound(REG_RADIUS_BOUND, {16'd0, $urandom()} >> $urandom_range(16));
		run_random(150, 7);
		write_bound(REG_RATIO_BOUND, 48'(24'($urandom())));
		write_bound(REG_RADIUS_BOUND, {$urandom(), 16'($urandom())});
		run_random(200, 81);
		write_bound(REG_RATIO_BOUND, 48'hFF_FFFF);
		write_bound(REG_RADIUS_BOUND, 48'd0);
		run_random(100, 81);
		write_bound(REG_RATIO_BOUND, 48'd65536);
		write_bound(REG_RADIUS_BOUND, 48'd1 << $urandom_range(30, 47));
		run_random(250, 0);

		wait_drained();
		repeat (70) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
